// ===== rtl/aco_pkg.sv =====
package aco_pkg;

  localparam int COMP_BITS_DEF = 8;
  localparam int SQ_STEPS      = 32;
  localparam int REM_W         = 35;
  localparam int RAD_W         = 64;
  localparam int CFG_IDX_W     = 4;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X   = 4'd0,
    REG_CENTRE_Y   = 4'd1,
    REG_RADIUS     = 4'd2,
    REG_X_SCALE    = 4'd3,
    REG_Y_SCALE    = 4'd4,
    REG_COLOUR     = 4'd5,
    REG_BASE_ALPHA = 4'd6,
    REG_COMP_COUNT = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] pix_x;
    logic signed [15:0] pix_y;
    logic               src_valid;
    logic [7:0]         src_comp0;
    logic [7:0]         src_comp1;
    logic [7:0]         src_comp2;
    logic [7:0]         src_comp3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_comp0;
    logic [7:0] out_comp1;
    logic [7:0] out_comp2;
    logic [7:0] out_comp3;
  } out_item_t;

  // one slot of the square-root chain
  typedef struct packed {
    logic             vld;
    logic             far;
    in_item_t         pix;
    logic [RAD_W-1:0] v;
    logic [REM_W-1:0] rem;
    logic [31:0]      root;
  } sq_slot_t;

endpackage

// ===== rtl/aco_sqrt_cell.sv =====
module aco_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  aco_pkg::sq_slot_t slot_i,
  output aco_pkg::sq_slot_t slot_o
);
  import aco_pkg::*;

  sq_slot_t         slot_r;
  sq_slot_t         slot_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  always_comb begin
    rem_sh   = {slot_i.rem[REM_W-3:0], slot_i.v[RAD_W-1 -: 2]};
    trial    = {1'b0, slot_i.root, 2'b01};
    slot_nxt = slot_i;
    slot_nxt.v = {slot_i.v[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      slot_nxt.rem  = rem_sh - trial;
      slot_nxt.root = {slot_i.root[30:0], 1'b1};
    end else begin
      slot_nxt.rem  = rem_sh;
      slot_nxt.root = {slot_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

// ===== rtl/aco_blend.sv =====
module aco_blend #(
  parameter int COMP_BITS = aco_pkg::COMP_BITS_DEF
) (
  input  aco_pkg::in_item_t  pix,
  input  logic [16:0]        alpha,
  input  logic [31:0]        colour_pixel,
  input  logic [2:0]         comp_count,
  output aco_pkg::out_item_t res
);
  import aco_pkg::*;

  localparam int EXT_W = 32 + 4 * COMP_BITS;
  localparam int PW    = COMP_BITS + 19;

  logic [EXT_W-1:0] ext;
  logic [7:0]       src [4];
  logic [7:0]       blended [4];
  logic [2:0]       n;

  assign ext = {{(EXT_W-32){1'b0}}, colour_pixel};
  assign n   = (comp_count > 3'd4) ? 3'd4 : comp_count;
  assign src[0] = pix.src_comp0;
  assign src[1] = pix.src_comp1;
  assign src[2] = pix.src_comp2;
  assign src[3] = pix.src_comp3;

  for (genvar c = 0; c < 4; c++) begin : g_comp
    logic [COMP_BITS-1:0]       col;
    logic [COMP_BITS-1:0]       s;
    logic signed [COMP_BITS:0]  diff;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       sum;

    always_comb begin
      col  = ext[c*COMP_BITS +: COMP_BITS];
      s    = pix.src_valid ? COMP_BITS'(src[c]) : '0;
      diff = $signed({1'b0, col}) - $signed({1'b0, s});
      prod = PW'(diff) * $signed(PW'({1'b0, alpha}));
      sum  = $signed(PW'({1'b0, s})) + (prod >>> 16);
      blended[c] = (3'(c) < n) ? sum[7:0] : 8'd0;
    end
  end

  assign res = '{out_comp0: blended[0], out_comp1: blended[1],
                 out_comp2: blended[2], out_comp3: blended[3]};

endmodule

// ===== rtl/antialiased_circle_overlay.sv =====
// Antialiased circle overlay: takes one pixel per clock and returns one blended
// pixel per clock while the output is not stalled. An item passes the coordinate
// mapping and squaring stages, 32 cells of the square-root chain, one alpha stage
// and one output register. The 32-cell chain resolves one distance bit per cell,
// so the whole pipe moves as one; it stalls as a unit only while a result waits
// at the output and out_ready is low. Configuration registers may be written only
// while no item is in flight.
module antialiased_circle_overlay #(
  parameter int COMP_BITS = aco_pkg::COMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  aco_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output aco_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import aco_pkg::*;

  logic signed [31:0] centre_x_r, centre_y_r;
  logic [30:0]        radius_r;
  logic [23:0]        x_scale_r, y_scale_r;
  logic [31:0]        colour_r;
  logic [16:0]        base_alpha_r;
  logic [2:0]         comp_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r   <= '0;
      centre_y_r   <= '0;
      radius_r     <= '0;
      x_scale_r    <= 24'd65536;
      y_scale_r    <= 24'd65536;
      colour_r     <= '0;
      base_alpha_r <= 17'd32768;
      comp_count_r <= 3'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTRE_X:   centre_x_r   <= cfg_data;
        REG_CENTRE_Y:   centre_y_r   <= cfg_data;
        REG_RADIUS:     radius_r     <= cfg_data[30:0];
        REG_X_SCALE:    x_scale_r    <= cfg_data[23:0];
        REG_Y_SCALE:    y_scale_r    <= cfg_data[23:0];
        REG_COLOUR:     colour_r     <= cfg_data;
        REG_BASE_ALPHA: base_alpha_r <= cfg_data[16:0];
        REG_COMP_COUNT: comp_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: scale the pixel centre
  logic               s0_v_r;
  in_item_t           s0_pix_r;
  logic signed [41:0] prodx_r, prody_r;

  // stage 1: offset from the centre
  logic               s1_v_r, s1_far_r;
  in_item_t           s1_pix_r;
  logic [30:0]        adx_r, ady_r;

  // stage 2: squares
  logic               s2_v_r, s2_far_r;
  in_item_t           s2_pix_r;
  logic [61:0]        sqx_r, sqy_r;

  // stage 3: radicand
  sq_slot_t           s3_r;

  logic signed [41:0] dx, dy;
  logic [41:0]        abx, aby;

  always_comb begin
    dx  = (prodx_r >>> 1) - 42'(centre_x_r);
    dy  = (prody_r >>> 1) - 42'(centre_y_r);
    abx = dx[41] ? 42'(-dx) : 42'(dx);
    aby = dy[41] ? 42'(-dy) : 42'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_r.vld <= 1'b0;
    end else if (en) begin
      s0_v_r   <= in_valid;
      s0_pix_r <= in_data;
      prodx_r  <= 42'($signed({in_data.pix_x, 1'b1})) * $signed(42'({1'b0, x_scale_r}));
      prody_r  <= 42'($signed({in_data.pix_y, 1'b1})) * $signed(42'({1'b0, y_scale_r}));

      s1_v_r   <= s0_v_r;
      s1_pix_r <= s0_pix_r;
      s1_far_r <= (|abx[41:31]) || (|aby[41:31]);
      adx_r    <= abx[30:0];
      ady_r    <= aby[30:0];

      s2_v_r   <= s1_v_r;
      s2_pix_r <= s1_pix_r;
      s2_far_r <= s1_far_r;
      sqx_r    <= 62'(adx_r) * 62'(adx_r);
      sqy_r    <= 62'(ady_r) * 62'(ady_r);

      s3_r.vld  <= s2_v_r;
      s3_r.far  <= s2_far_r;
      s3_r.pix  <= s2_pix_r;
      s3_r.v    <= RAD_W'(sqx_r) + RAD_W'(sqy_r);
      s3_r.rem  <= '0;
      s3_r.root <= '0;
    end
  end

  sq_slot_t chain [SQ_STEPS+1];
  assign chain[0] = s3_r;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
    aco_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .slot_i (chain[i]),
      .slot_o (chain[i+1])
    );
  end

  // alpha stage
  sq_slot_t    last;
  logic [16:0] ba;
  logic [32:0] d_ext;
  logic [15:0] depth;
  logic [32:0] edge_prod;
  logic [16:0] alpha_nxt;
  logic        a_v_r;
  in_item_t    a_pix_r;
  logic [16:0] alpha_r;

  assign last = chain[SQ_STEPS];

  always_comb begin
    ba        = (base_alpha_r > ONE_Q16) ? ONE_Q16 : base_alpha_r;
    d_ext     = {1'b0, last.root};
    depth     = 16'(33'(radius_r) - d_ext);
    edge_prod = 33'(ba) * 33'(depth);
    alpha_nxt = '0;
    if (!last.far && d_ext < 33'(radius_r)) begin
      if (d_ext + 33'(ONE_Q16) > 33'(radius_r)) begin
        alpha_nxt = edge_prod[32:16];
      end else begin
        alpha_nxt = ba;
      end
    end
  end

  out_item_t blend_res;
  out_item_t out_data_r;
  logic      out_valid_r;

  aco_blend #(.COMP_BITS(COMP_BITS)) u_blend (
    .pix          (a_pix_r),
    .alpha        (alpha_r),
    .colour_pixel (colour_r),
    .comp_count   (comp_count_r),
    .res          (blend_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_v_r       <= last.vld;
      a_pix_r     <= last.pix;
      alpha_r     <= alpha_nxt;
      out_valid_r <= a_v_r;
      out_data_r  <= blend_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/aco_checker.sv =====
module aco_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input aco_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with an empty output");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalls");

endmodule

bind antialiased_circle_overlay aco_checker u_aco_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import aco_pkg::*;

  localparam int PIPE_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow copy of the overlay registers
  longint circ_cx, circ_cy, circ_rad, scale_x, scale_y, alpha_base;
  logic [31:0] overlay_colour;
  int unsigned comp_count;

  out_item_t expected_pixels[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;

  antialiased_circle_overlay DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic out_item_t blend_pixel(in_item_t p);
    longint px, py, xc, yc, dx, dy, ba, alpha, d, s, col, v;
    int unsigned n;
    logic [7:0] src [4];
    logic [7:0] res [4];
    out_item_t r;
    px = p.pix_x;
    py = p.pix_y;
    xc = ((2 * px + 1) * scale_x) >>> 1;
    yc = ((2 * py + 1) * scale_y) >>> 1;
    dx = xc - circ_cx;
    dy = yc - circ_cy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    ba = (alpha_base > 65536) ? 65536 : alpha_base;
    alpha = 0;
    if (dx < 64'sd2147483648 && dy < 64'sd2147483648) begin
      d = longint'(int_sqrt(longint'(dx * dx) + longint'(dy * dy)));
      if (d < circ_rad) begin
        if (d > circ_rad - 65536) alpha = (ba * (circ_rad - d)) >>> 16;
        else alpha = ba;
      end
    end
    n = (comp_count > 4) ? 4 : comp_count;
    src[0] = p.src_comp0;
    src[1] = p.src_comp1;
    src[2] = p.src_comp2;
    src[3] = p.src_comp3;
    for (int c = 0; c < 4; c++) begin
      res[c] = 8'd0;
      if (c < n) begin
        s = p.src_valid ? longint'(src[c]) : 0;
        col = longint'(overlay_colour[c*8 +: 8]);
        v = s + (((col - s) * alpha) >>> 16);
        res[c] = v[7:0];
      end
    end
    r.out_comp0 = res[0];
    r.out_comp1 = res[1];
    r.out_comp2 = res[2];
    r.out_comp3 = res[3];
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_gaps || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic send_pixel(in_item_t p);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(blend_pixel(p));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTRE_X:   circ_cx = longint'($signed(val));
      REG_CENTRE_Y:   circ_cy = longint'($signed(val));
      REG_RADIUS:     circ_rad = longint'(val[30:0]);
      REG_X_SCALE:    scale_x = longint'(val[23:0]);
      REG_Y_SCALE:    scale_y = longint'(val[23:0]);
      REG_COLOUR:     overlay_colour = val;
      REG_BASE_ALPHA: alpha_base = longint'(val[16:0]);
      REG_COMP_COUNT: comp_count = 32'(val[2:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_circle(longint cx, longint cy, longint rad, longint sx, longint sy,
                            logic [31:0] colour, longint ba, int cnt);
    wait_drained();
    write_reg(REG_CENTRE_X, cx[31:0]);
    write_reg(REG_CENTRE_Y, cy[31:0]);
    write_reg(REG_RADIUS, rad[31:0]);
    write_reg(REG_X_SCALE, sx[31:0]);
    write_reg(REG_Y_SCALE, sy[31:0]);
    write_reg(REG_COLOUR, colour);
    write_reg(REG_BASE_ALPHA, ba[31:0]);
    write_reg(REG_COMP_COUNT, 32'(cnt));
  endtask

  function automatic in_item_t noise_pixel();
    in_item_t p;
    p.pix_x = 16'($urandom);
    p.pix_y = 16'($urandom);
    p.src_valid = 1'($urandom);
    {p.src_comp0, p.src_comp1, p.src_comp2, p.src_comp3} = $urandom;
    return p;
  endfunction

  // pick a pixel whose canonical position lies near the circle
  function automatic in_item_t near_pixel();
    in_item_t p;
    longint span, tx, ty;
    p = noise_pixel();
    span = circ_rad + 3 * 65536;
    tx = circ_cx + $urandom_range(0, 2 * span) - span;
    ty = circ_cy + $urandom_range(0, 2 * span) - span;
    if (scale_x != 0) p.pix_x = 16'(tx / scale_x);
    if (scale_y != 0) p.pix_y = 16'(ty / scale_y);
    return p;
  endfunction

  function automatic in_item_t make_pixel(int x, int y, bit sv, logic [31:0] comps);
    in_item_t p;
    p.pix_x = 16'(x);
    p.pix_y = 16'(y);
    p.src_valid = sv;
    {p.src_comp3, p.src_comp2, p.src_comp1, p.src_comp0} = comps;
    return p;
  endfunction

  task automatic test_reset_values();
    send_pixel(make_pixel(0, 0, 1, 32'h80FF0011));
    send_pixel(make_pixel(-32768, 32767, 1, 32'hFFFFFFFF));
    send_pixel(make_pixel(32767, -32768, 0, 32'h12345678));
  endtask

  task automatic test_directed();
    // small circle at the origin, full opacity, white overlay
    set_circle(0, 0, 5 * 65536, 65536, 65536, 32'hFFFFFFFF, 65536, 4);
    send_pixel(make_pixel(0, 0, 1, 32'h00000000));
    send_pixel(make_pixel(3, 2, 1, 32'h40302010));
    send_pixel(make_pixel(4, 0, 1, 32'h40302010));
    send_pixel(make_pixel(-5, -1, 1, 32'hFFFFFFFF));
    send_pixel(make_pixel(10, 10, 1, 32'h55AA55AA));
    send_pixel(make_pixel(2, 2, 0, 32'hFFFFFFFF));
    send_pixel(make_pixel(-32768, -32768, 1, 32'h01020304));
    send_pixel(make_pixel(32767, 32767, 1, 32'h01020304));
    // radius below one unit: everything inside is edge band
    set_circle(-32768, 32768, 40000, 65536, 65536, 32'h00FF7F01, 131071, 2);
    send_pixel(make_pixel(-1, 0, 1, 32'hFFFFFFFF));
    send_pixel(make_pixel(0, 0, 1, 32'h10101010));
    send_pixel(make_pixel(-1, 0, 0, 32'h10101010));
    // far pixels through huge scale
    set_circle(0, 0, 32'h7FFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hA5A5A5A5, 65535, 3);
    send_pixel(make_pixel(0, 0, 1, 32'h5A5A5A5A));
    send_pixel(make_pixel(200, 0, 1, 32'h5A5A5A5A));
    send_pixel(make_pixel(-32768, 5, 1, 32'h5A5A5A5A));
    set_circle(0, 0, 65536 * 3, 65536, 65536, 32'hFFFFFFFF, 65536, 0);
    send_pixel(make_pixel(0, 0, 1, 32'h11223344));
    set_circle(0, 0, 65536 * 3, 65536, 65536, 32'hFFFFFFFF, 65536, 7);
    send_pixel(make_pixel(0, 0, 1, 32'h11223344));
    send_pixel(make_pixel(2, 0, 1, 32'h11223344));
  endtask

  task automatic test_random_circles();
    longint sx, sy, cx, cy;
    int kind;
    for (int ph = 0; ph < 8; ph++) begin
      kind = $urandom_range(0, 3);
      sx = (kind == 0) ? 65536 : (kind == 1) ? 32768 : $urandom_range(20000, 200000);
      sy = (kind == 0) ? 65536 : $urandom_range(20000, 200000);
      cx = longint'($signed(16'($urandom))) * sx / 4;
      cy = longint'($signed(16'($urandom))) * sy / 4;
      set_circle(cx, cy, $urandom_range(0, 80 * 65536), sx, sy, $urandom,
                 $urandom_range(0, 70000), $urandom_range(0, 7));
      no_gaps = (ph % 3 == 2);
      for (int i = 0; i < 150; i++) begin
        if (i == 75) begin
          // hold off until the pipe has emptied
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_pixels.size() != 0) @(posedge clk);
        end
        send_pixel(($urandom_range(0, 9) < 8) ? near_pixel() : noise_pixel());
      end
      no_gaps = 0;
    end
  endtask

  task automatic test_extremes();
    set_circle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 24'hFFFFFF, 32'hFFFFFFFF,
               65536, 4);
    for (int i = 0; i < 60; i++) send_pixel(noise_pixel());
    set_circle(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 0, 32'h00000000,
               131071, 1);
    for (int i = 0; i < 60; i++) send_pixel(noise_pixel());
    set_circle(0, 0, 200 * 65536, 65536, 65536, 32'h80402010, 0, 4);
    for (int i = 0; i < 60; i++) send_pixel(near_pixel());
    set_circle(0, 0, 0, 65536, 65536, 32'hFFFFFFFF, 65536, 4);
    for (int i = 0; i < 60; i++) send_pixel(near_pixel());
  endtask

  // result side: stall a random number of cycles before each item
  initial begin
    int k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      k = draw_gap();
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected item out_data=%h", out_data);
        fail_count++;
      end else begin
        out_item_t e;
        e = expected_pixels.pop_front();
        if (out_data.out_comp0 !== e.out_comp0) begin
          $error("out_comp0 expected %0d actual %0d", e.out_comp0, out_data.out_comp0);
          fail_count++;
        end
        if (out_data.out_comp1 !== e.out_comp1) begin
          $error("out_comp1 expected %0d actual %0d", e.out_comp1, out_data.out_comp1);
          fail_count++;
        end
        if (out_data.out_comp2 !== e.out_comp2) begin
          $error("out_comp2 expected %0d actual %0d", e.out_comp2, out_data.out_comp2);
          fail_count++;
        end
        if (out_data.out_comp3 !== e.out_comp3) begin
          $error("out_comp3 expected %0d actual %0d", e.out_comp3, out_data.out_comp3);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    circ_cx = 0;
    circ_cy = 0;
    circ_rad = 0;
    scale_x = 65536;
    scale_y = 65536;
    overlay_colour = 0;
    alpha_base = 32768;
    comp_count = 4;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random_circles();
    test_extremes();
    wait_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
